### src/process_scheduler_fcfs_sjf_prio_rr_assert.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by the files that check their own logic.
`ifndef PROCESS_SCHEDULER_FCFS_SJF_PRIO_RR_ASSERT_SVH
`define PROCESS_SCHEDULER_FCFS_SJF_PRIO_RR_ASSERT_SVH

// expression must hold on every clock edge out of reset
`define PSCH_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("scheduler check failed");

// consequent must hold in the same cycle as the antecedent
`define PSCH_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

`endif

### src/psch_pkg.sv
// Shared types and constants for the process scheduler.
// No dependencies; used by every scheduler module.
package psch_pkg;

   localparam int MAX_PROCS_DEF = 16;

   localparam int PID_W    = 16;
   localparam int TIME_W   = 16;
   localparam int URG_W    = 8;
   localparam int CLK_W    = 21;
   localparam int MODE_W   = 2;
   localparam int QUANT_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'd1;

   localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_EMIT,
      ST_POP,
      ST_SLICE_RD,
      ST_SLICE_EX,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_we;
      logic drop;
      logic scan_rd;
      logic scan_init;
      logic clk_jump;
      logic pick_best;
      logic admit;
      logic push_sel;
      logic ring_rd;
      logic slice_rd;
      logic slice_exec;
      logic emit;
      logic emit_last;
      logic mark_sel;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_rr;
      logic any;
      logic found;
      logic adm_ok;
      logic rem_zero;
      logic out_free;
   } status_type;

endpackage

### src/psch_if.sv
// Handshake channel interfaces for process records and completion records.
// Depends on psch_pkg for field widths.
interface psch_req_if;
   logic                           valid;
   logic                           ready;
   logic [psch_pkg::PID_W-1:0]     pid;
   logic [psch_pkg::TIME_W-1:0]    arrival_time;
   logic [psch_pkg::TIME_W-1:0]    burst_time;
   logic [psch_pkg::URG_W-1:0]     urgency;
   logic                           last;

   modport source (output valid, pid, arrival_time, burst_time, urgency, last, input ready);
   modport sink   (input valid, pid, arrival_time, burst_time, urgency, last, output ready);
endinterface

interface psch_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [psch_pkg::PID_W-1:0]     done_pid;
   logic [psch_pkg::CLK_W-1:0]     completion_time;
   logic [psch_pkg::CLK_W-1:0]     turnaround_time;
   logic [psch_pkg::CLK_W-1:0]     waiting_time;
   logic                           overflow;
   logic                           end_of_run;

   modport source (output valid, done_pid, completion_time, turnaround_time, waiting_time,
                   overflow, end_of_run, input ready);
   modport sink   (input valid, done_pid, completion_time, turnaround_time, waiting_time,
                   overflow, end_of_run, output ready);
endinterface

### src/psch_datapath.sv
// Scheduler datapath: record stores, ready ring, selection unit, clock and result register.
// Depends on psch_pkg; driven by psch_ctrl through cmd_type and status_type.
module psch_datapath #(
   parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF,
   localparam int IW = $clog2(MAX_PROCS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  psch_pkg::cmd_type                 cmd,
   output psch_pkg::status_type              status,
   input  logic [IW-1:0]                     load_addr,
   input  logic [IW-1:0]                     scan_addr,
   input  logic [IW-1:0]                     ring_wr_addr,
   input  logic [IW-1:0]                     ring_rd_addr,
   input  logic [psch_pkg::PID_W-1:0]        in_pid,
   input  logic [psch_pkg::TIME_W-1:0]       in_arrival,
   input  logic [psch_pkg::TIME_W-1:0]       in_burst,
   input  logic [psch_pkg::URG_W-1:0]        in_urgency,
   input  logic                              csr_we,
   input  logic [psch_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psch_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [psch_pkg::PID_W-1:0]        out_pid,
   output logic [psch_pkg::CLK_W-1:0]        out_completion,
   output logic [psch_pkg::CLK_W-1:0]        out_turnaround,
   output logic [psch_pkg::CLK_W-1:0]        out_waiting,
   output logic                              out_overflow,
   output logic                              out_end
);

   localparam int TW = psch_pkg::TIME_W;
   localparam int CW = psch_pkg::CLK_W;

   logic [psch_pkg::PID_W-1:0] id_mem  [MAX_PROCS];
   logic [TW-1:0]              arr_mem [MAX_PROCS];
   logic [TW-1:0]              bur_mem [MAX_PROCS];
   logic [TW-1:0]              rem_mem [MAX_PROCS];
   logic [psch_pkg::URG_W-1:0] urg_mem [MAX_PROCS];
   logic [IW-1:0]              ring_mem[MAX_PROCS];

   logic [psch_pkg::MODE_W-1:0]  mode_ff;
   logic [psch_pkg::QUANT_W-1:0] quantum_ff;

   logic [psch_pkg::PID_W-1:0] rd_id_ff;
   logic [TW-1:0]              rd_arr_ff, rd_bur_ff, rd_rem_ff;
   logic [psch_pkg::URG_W-1:0] rd_urg_ff;
   logic [IW-1:0]              ring_q_ff, sidx_ff;

   logic                       ev_valid_ff;
   logic [IW-1:0]              ev_idx_ff;
   logic                       any_ff, found_ff;
   logic [TW-1:0]              nxt_ff, bkey_ff, barr_ff, bbur_ff;
   logic [IW-1:0]              bidx_ff;
   logic [psch_pkg::PID_W-1:0] bid_ff;

   logic [IW-1:0]              sel_idx_ff;
   logic [TW-1:0]              sel_arr_ff, sel_bur_ff;
   logic [psch_pkg::PID_W-1:0] sel_id_ff;
   logic                       rem_zero_ff;

   logic [CW-1:0]              clock_ff;
   logic [MAX_PROCS-1:0]       mark_ff;
   logic                       dropped_ff;

   logic                       out_valid_ff, out_ovf_ff, out_end_ff;
   logic [psch_pkg::PID_W-1:0] out_pid_ff;
   logic [CW-1:0]              out_comp_ff, out_tat_ff, out_wait_ff;

   logic                       is_rr;
   logic [IW-1:0]              rd_addr;
   logic                       rd_en;
   logic [TW-1:0]              quant_eff, ex, rem_left, key;
   logic                       rem_we, elig, take;
   logic [IW-1:0]              rem_waddr;
   logic [TW-1:0]              rem_wdata;
   logic [CW-1:0]              tat, wait_t;

   assign is_rr     = (mode_ff == psch_pkg::MODE_RR);
   assign rd_addr   = cmd.slice_rd ? ring_q_ff : scan_addr;
   assign rd_en     = cmd.scan_rd | cmd.slice_rd;
   assign quant_eff = (quantum_ff == '0) ? TW'(1) : quantum_ff;
   assign ex        = (rd_rem_ff < quant_eff) ? rd_rem_ff : quant_eff;
   assign rem_left  = rd_rem_ff - ex;
   assign rem_we    = cmd.load_we | cmd.slice_exec;
   assign rem_waddr = cmd.load_we ? load_addr : sidx_ff;
   assign rem_wdata = cmd.load_we ? in_burst : rem_left;

   always_comb begin
      case (mode_ff)
         psch_pkg::MODE_SJF:  key = rd_bur_ff;
         psch_pkg::MODE_PRIO: key = {{(TW-psch_pkg::URG_W){1'b0}}, rd_urg_ff};
         default:             key = rd_arr_ff;
      endcase
   end

   assign elig = is_rr | ({{(CW-TW){1'b0}}, rd_arr_ff} <= clock_ff);
   assign take = ev_valid_ff & ~mark_ff[ev_idx_ff] & elig & (~found_ff | (key < bkey_ff));

   assign tat    = clock_ff - {{(CW-TW){1'b0}}, sel_arr_ff};
   assign wait_t = tat - {{(CW-TW){1'b0}}, sel_bur_ff};

   // stores
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         id_mem[load_addr]  <= in_pid;
         arr_mem[load_addr] <= in_arrival;
         bur_mem[load_addr] <= in_burst;
         urg_mem[load_addr] <= in_urgency;
      end
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      if (rd_en) begin
         rd_id_ff  <= id_mem[rd_addr];
         rd_arr_ff <= arr_mem[rd_addr];
         rd_bur_ff <= bur_mem[rd_addr];
         rd_urg_ff <= urg_mem[rd_addr];
         rd_rem_ff <= rem_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.admit) begin
         ring_mem[ring_wr_addr] <= bidx_ff;
      end else if (cmd.push_sel) begin
         ring_mem[ring_wr_addr] <= sel_idx_ff;
      end
      if (cmd.ring_rd) begin
         ring_q_ff <= ring_mem[ring_rd_addr];
      end
      if (cmd.slice_rd) begin
         sidx_ff <= ring_q_ff;
      end
   end

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= psch_pkg::MODE_FCFS;
         quantum_ff <= psch_pkg::QUANT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            psch_pkg::CSR_MODE:    mode_ff    <= csr_wdata[psch_pkg::MODE_W-1:0];
            psch_pkg::CSR_QUANTUM: quantum_ff <= csr_wdata[psch_pkg::QUANT_W-1:0];
            default: ;
         endcase
      end
   end

   // selection unit
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
         any_ff      <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         ev_valid_ff <= cmd.scan_rd;
         if (cmd.scan_init) begin
            any_ff   <= 1'b0;
            found_ff <= 1'b0;
         end else if (ev_valid_ff && !mark_ff[ev_idx_ff]) begin
            any_ff <= 1'b1;
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= scan_addr;
      if (ev_valid_ff && !mark_ff[ev_idx_ff] && (!any_ff || rd_arr_ff < nxt_ff)) begin
         nxt_ff <= rd_arr_ff;
      end
      if (take) begin
         bkey_ff <= key;
         bidx_ff <= ev_idx_ff;
         barr_ff <= rd_arr_ff;
         bbur_ff <= rd_bur_ff;
         bid_ff  <= rd_id_ff;
      end
      if (cmd.pick_best) begin
         sel_idx_ff <= bidx_ff;
         sel_arr_ff <= barr_ff;
         sel_bur_ff <= bbur_ff;
         sel_id_ff  <= bid_ff;
      end else if (cmd.slice_exec) begin
         sel_idx_ff  <= sidx_ff;
         sel_arr_ff  <= rd_arr_ff;
         sel_bur_ff  <= rd_bur_ff;
         sel_id_ff   <= rd_id_ff;
         rem_zero_ff <= (rem_left == '0);
      end
   end

   // run clock, marks, drop flag
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         clock_ff   <= '0;
         mark_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         if (cmd.clk_jump) begin
            clock_ff <= {{(CW-TW){1'b0}}, nxt_ff};
         end else if (cmd.pick_best) begin
            clock_ff <= clock_ff + {{(CW-TW){1'b0}}, bbur_ff};
         end else if (cmd.slice_exec) begin
            clock_ff <= clock_ff + {{(CW-TW){1'b0}}, ex};
         end
         if (cmd.admit) begin
            mark_ff[bidx_ff] <= 1'b1;
         end
         if (cmd.mark_sel) begin
            mark_ff[sel_idx_ff] <= 1'b1;
         end
         if (cmd.drop) begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_pid_ff  <= sel_id_ff;
         out_comp_ff <= clock_ff;
         out_tat_ff  <= tat;
         out_wait_ff <= wait_t;
         out_ovf_ff  <= dropped_ff;
         out_end_ff  <= cmd.emit_last;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_pid        = out_pid_ff;
   assign out_completion = out_comp_ff;
   assign out_turnaround = out_tat_ff;
   assign out_waiting    = out_wait_ff;
   assign out_overflow   = out_ovf_ff;
   assign out_end        = out_end_ff;

   assign status.is_rr    = is_rr;
   assign status.any      = any_ff;
   assign status.found    = found_ff;
   assign status.adm_ok   = found_ff & ({{(CW-TW){1'b0}}, barr_ff} <= clock_ff);
   assign status.rem_zero = rem_zero_ff;
   assign status.out_free = ~out_valid_ff | out_ready;

endmodule

### src/psch_ctrl.sv
// Scheduler controller: load counting, table scans, ready ring pointers and run sequencing.
// Depends on psch_pkg and the assertion macro header; drives psch_datapath.
`include "process_scheduler_fcfs_sjf_prio_rr_assert.svh"

module psch_ctrl #(
   parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF,
   localparam int IW = $clog2(MAX_PROCS),
   localparam int CW = $clog2(MAX_PROCS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output psch_pkg::cmd_type     cmd,
   input  psch_pkg::status_type  status,
   output logic [IW-1:0]         load_addr,
   output logic [IW-1:0]         scan_addr,
   output logic [IW-1:0]         ring_wr_addr,
   output logic [IW-1:0]         ring_rd_addr
);

   psch_pkg::state_type state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] done_ff, done_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] head_ff, head_in;
   logic          post_ff, post_in;
   logic [CW:0]   wsum;
   logic          is_last_done;

   assign wsum = (CW+1)'(head_ff) + (CW+1)'(rcnt_ff);
   assign ring_wr_addr = (wsum >= (CW+1)'(MAX_PROCS)) ?
                         IW'(wsum - (CW+1)'(MAX_PROCS)) : IW'(wsum);
   assign ring_rd_addr = head_ff;
   assign load_addr    = IW'(n_ff);
   assign scan_addr    = cnt_ff;
   assign is_last_done = ((done_ff + CW'(1)) == n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psch_pkg::ST_IDLE;
         n_ff     <= '0;
         done_ff  <= '0;
         rcnt_ff  <= '0;
         cnt_ff   <= '0;
         head_ff  <= '0;
         post_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         done_ff  <= done_in;
         rcnt_ff  <= rcnt_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         post_ff  <= post_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      done_in   = done_ff;
      rcnt_in   = rcnt_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      post_in   = post_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         psch_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (n_ff < CW'(MAX_PROCS)) begin
                  cmd.load_we = 1'b1;
                  n_in        = n_ff + CW'(1);
               end else begin
                  cmd.drop = 1'b1;
               end
               if (req_last) begin
                  state_in = psch_pkg::ST_SCAN;
                  cnt_in   = '0;
                  done_in  = '0;
                  rcnt_in  = '0;
                  head_in  = '0;
                  post_in  = 1'b0;
               end
            end
         end
         psch_pkg::ST_SCAN: begin
            cmd.scan_rd   = 1'b1;
            cmd.scan_init = (cnt_ff == '0);
            if (CW'(cnt_ff) == n_ff - CW'(1)) begin
               state_in = psch_pkg::ST_SCAN_END;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         psch_pkg::ST_SCAN_END: begin
            state_in = psch_pkg::ST_DECIDE;
         end
         psch_pkg::ST_DECIDE: begin
            cnt_in = '0;
            if (!status.is_rr) begin
               if (status.found) begin
                  cmd.pick_best = 1'b1;
                  state_in      = psch_pkg::ST_EMIT;
               end else if (status.any) begin
                  cmd.clk_jump = 1'b1;
                  state_in     = psch_pkg::ST_SCAN;
               end else begin
                  state_in = psch_pkg::ST_FINISH;
               end
            end else if (status.adm_ok) begin
               cmd.admit = 1'b1;
               rcnt_in   = rcnt_ff + CW'(1);
               state_in  = psch_pkg::ST_SCAN;
            end else if (!post_ff) begin
               if (rcnt_ff != '0) begin
                  state_in = psch_pkg::ST_POP;
               end else if (status.found) begin
                  cmd.clk_jump = 1'b1;
                  state_in     = psch_pkg::ST_SCAN;
               end else begin
                  state_in = psch_pkg::ST_FINISH;
               end
            end else if (status.rem_zero) begin
               state_in = psch_pkg::ST_EMIT;
            end else begin
               cmd.push_sel = 1'b1;
               rcnt_in      = rcnt_ff + CW'(1);
               post_in      = 1'b0;
               state_in     = psch_pkg::ST_SCAN;
            end
         end
         psch_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = is_last_done;
               cmd.mark_sel  = ~status.is_rr;
               done_in       = done_ff + CW'(1);
               post_in       = 1'b0;
               cnt_in        = '0;
               state_in      = is_last_done ? psch_pkg::ST_FINISH : psch_pkg::ST_SCAN;
            end
         end
         psch_pkg::ST_POP: begin
            cmd.ring_rd = 1'b1;
            head_in     = (head_ff == IW'(MAX_PROCS - 1)) ? '0 : head_ff + IW'(1);
            rcnt_in     = rcnt_ff - CW'(1);
            state_in    = psch_pkg::ST_SLICE_RD;
         end
         psch_pkg::ST_SLICE_RD: begin
            cmd.slice_rd = 1'b1;
            state_in     = psch_pkg::ST_SLICE_EX;
         end
         psch_pkg::ST_SLICE_EX: begin
            cmd.slice_exec = 1'b1;
            post_in        = 1'b1;
            cnt_in         = '0;
            state_in       = psch_pkg::ST_SCAN;
         end
         psch_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            n_in       = '0;
            state_in   = psch_pkg::ST_IDLE;
         end
         default: begin
            state_in = psch_pkg::ST_IDLE;
         end
      endcase
   end

   `PSCH_ASSERT_ALWAYS(a_load_cap, clock, reset, n_ff <= CW'(MAX_PROCS))
   `PSCH_ASSERT_ALWAYS(a_ring_cap, clock, reset, rcnt_ff <= n_ff)
   `PSCH_ASSERT_IMPLIES(a_emit_free, clock, reset, cmd.emit, status.out_free)
   `PSCH_ASSERT_IMPLIES(a_emit_count, clock, reset, state_ff == psch_pkg::ST_EMIT, done_ff < n_ff)

endmodule

### src/process_scheduler_fcfs_sjf_prio_rr.sv
// Process scheduler (FCFS, SJF, priority, round robin). Records load at one beat per cycle
// while idle into a MAX_PROCS-entry table; the beat flagged last starts the run and the
// request side stays stalled until the last completion beat is in the output register.
// Each selection walks the table once through the registered store read port; an idle gap
// costs a further walk. Round robin spends one walk per admission to the ready ring and two
// per slice, plus the ring pop and slice update (ST_POP, ST_SLICE_RD, ST_SLICE_EX) and the
// ST_EMIT state for each completion beat. A completion beat waits in the output register
// while the next selection proceeds. Mode and quantum are to be written only idle: the user
// must keep to this, as the block itself does not enforce it.
module process_scheduler_fcfs_sjf_prio_rr #(
   parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   psch_req_if.sink                         req,
   psch_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [psch_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psch_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_PROCS);

   psch_pkg::cmd_type    cmd;
   psch_pkg::status_type status;
   logic [IW-1:0]        load_addr, scan_addr, ring_wr_addr, ring_rd_addr;

   psch_ctrl #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_last     (req.last),
      .req_ready    (req.ready),
      .cmd          (cmd),
      .status       (status),
      .load_addr    (load_addr),
      .scan_addr    (scan_addr),
      .ring_wr_addr (ring_wr_addr),
      .ring_rd_addr (ring_rd_addr)
   );

   psch_datapath #(.MAX_PROCS(MAX_PROCS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .load_addr      (load_addr),
      .scan_addr      (scan_addr),
      .ring_wr_addr   (ring_wr_addr),
      .ring_rd_addr   (ring_rd_addr),
      .in_pid         (req.pid),
      .in_arrival     (req.arrival_time),
      .in_burst       (req.burst_time),
      .in_urgency     (req.urgency),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .out_valid      (rsp.valid),
      .out_ready      (rsp.ready),
      .out_pid        (rsp.done_pid),
      .out_completion (rsp.completion_time),
      .out_turnaround (rsp.turnaround_time),
      .out_waiting    (rsp.waiting_time),
      .out_overflow   (rsp.overflow),
      .out_end        (rsp.end_of_run)
   );

endmodule
